@@ hdl/rtufc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtufc_pkg
// Shared types, constants and the byte-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package rtufc_pkg;

	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_START = 16'hFFFF;

	localparam logic [7:0]  OWN_ADDRESS_RESET = 8'd1;

	// register index on the configuration port
	localparam logic        REG_OWN_ADDRESS = 1'b0;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_BAD_ADDRESS = 2'd1,
		STATUS_BAD_CRC     = 2'd2
	} frame_status_t;

	// one byte through the reflected CRC, eight shift steps
	function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ hdl/rtufc_apb_regs.sv @@
// ----------------------------------------------------------------------------
// rtufc_apb_regs
// APB register bank holding the slave address.
// ----------------------------------------------------------------------------
module rtufc_apb_regs
	import rtufc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  own_address
);

	logic [7:0] own_address_q;
	logic       wr_en;
	logic       reg_index;

	assign pready    = 1'b1;
	assign reg_index = paddr[2];
	assign wr_en     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= OWN_ADDRESS_RESET;
		end else if (wr_en && (reg_index == REG_OWN_ADDRESS)) begin
			own_address_q <= pwdata[7:0];
		end
	end

	always_comb begin
		if (reg_index == REG_OWN_ADDRESS) begin
			prdata = {24'h000000, own_address_q};
		end else begin
			prdata = 32'h00000000;
		end
	end

	assign own_address = own_address_q;

endmodule

@@ hdl/rtufc_frame_check.sv @@
// ----------------------------------------------------------------------------
// rtufc_frame_check
// Input register, running CRC and address flags, and result register.
// ----------------------------------------------------------------------------
module rtufc_frame_check
	import rtufc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] own_address,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] out_status
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic [15:0]   crc_q;
	logic          at_start_q;
	logic          addr_match_q;
	logic          out_valid_q;
	frame_status_t status_q;

	logic          out_free;
	logic          adv_s1;
	logic          match_now;
	logic [15:0]   crc_next;
	frame_status_t status_next;

	assign out_free = !out_valid_q || out_ready;
	// a last byte waits until the result register has room
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign match_now = at_start_q ? (byte_s1 == own_address) : addr_match_q;
	assign crc_next  = crc_byte_update(crc_q, byte_s1);

	always_comb begin
		if (!match_now) begin
			status_next = STATUS_BAD_ADDRESS;
		end else if (crc_next != 16'h0000) begin
			status_next = STATUS_BAD_CRC;
		end else begin
			status_next = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_START;
			at_start_q   <= 1'b1;
			addr_match_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				crc_q        <= CRC_START;
				at_start_q   <= 1'b1;
				addr_match_q <= 1'b0;
			end else begin
				crc_q        <= crc_next;
				at_start_q   <= 1'b0;
				addr_match_q <= match_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			status_q <= status_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;

	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> out_valid_q)
		else $error("no result after the last word of a frame");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (crc_q == CRC_START && at_start_q && !addr_match_q))
		else $error("frame state not cleared after the last word");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(byte_s1) && $stable(last_s1)))
		else $error("stalled input word lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(adv_s1 && last_s1))
		else $error("pending result overwritten");

endmodule

@@ hdl/rtu_frame_address_crc_check_core.sv @@
// ----------------------------------------------------------------------------
// rtu_frame_address_crc_check_core
// Modbus RTU receive frame checker: slave address and CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the received frame bytes on the s_axis channel, address byte first,
//   the two CRC bytes last (low byte first), with s_axis_tlast on the final
//   byte. One status word per frame leaves on m_axis: 0 ok, 1 address
//   mismatch, 2 CRC error; the address check takes precedence.
//   The APB port holds the slave address at byte address 0 (reset 1).
// Timing:
//   One byte per cycle sustained, but a last byte waits in the input
//   register until the result register is free. A byte goes into the
//   input register, then through the byte-wide CRC update into the state
//   registers; the last byte's status goes into the result register.
// Reset and stalls:
//   arst_n clears the CRC to 0xFFFF and the frame flags. While m_axis_tready
//   is low a pending status holds; bytes of the next frame keep flowing
//   until its own last byte reaches the input register, which then holds
//   and drops s_axis_tready.
// ----------------------------------------------------------------------------
module rtu_frame_address_crc_check_core
	import rtufc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// frame bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
	input  logic        s_axis_tlast,   // frame_end
	// frame status
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [1:0] frame_status, [7:2] zero
);

	logic [7:0] own_address;
	logic [1:0] frame_status;

	rtufc_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.own_address (own_address)
	);

	rtufc_frame_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_address (own_address),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_status  (frame_status)
	);

	assign m_axis_tdata = {6'b000000, frame_status};

endmodule
